[rtl/core/bfim_pkg.sv]
package bfim_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_FILTER_BYTES = 2'd0;
    localparam logic [1:0] REG_HASH_COUNT   = 2'd1;
    localparam logic [1:0] REG_TWEAK        = 2'd2;
    localparam logic [1:0] REG_SEED_STEP    = 2'd3;

    // Input action codes.
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // MurmurHash3 x86_32 constants.
    localparam logic [31:0] MM3_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MM3_C2 = 32'h1b873593;
    localparam logic [31:0] MM3_N  = 32'he6546b64;
    localparam logic [31:0] MM3_F1 = 32'h85ebca6b;
    localparam logic [31:0] MM3_F2 = 32'hc2b2ae35;
    localparam logic [31:0] SEED_STEP_RESET = 32'hfba4c795;

    // Operations of the shared hash datapath.
    typedef enum logic [3:0] {
        OP_LOAD_SEED = 4'd0,  // h = seed_acc
        OP_K_MUL1    = 4'd1,  // k = k * C1
        OP_K_MUL2    = 4'd2,  // k = rotl(k,15) * C2
        OP_H_BLOCK   = 4'd3,  // h = rotl(h ^ k, 13)
        OP_H_MUL5    = 4'd4,  // h = h * 5 + N
        OP_H_TAIL    = 4'd5,  // h = h ^ k
        OP_FIN_LEN   = 4'd6,  // h ^= len; h ^= h >> 16
        OP_FIN_MUL1  = 4'd7,  // h *= F1; h ^= h >> 13
        OP_FIN_MUL2  = 4'd8,  // h *= F2; h ^= h >> 16
        OP_SEED_NEXT = 4'd9,  // seed_acc += seed_step
        OP_NONE      = 4'd10
    } hash_op_t;

endpackage

[rtl/core/bloom_filter_insert_murmur3.sv]
// Bloom filter insert engine with MurmurHash3 x86_32 hashing.
// Input channel (in_valid/in_stall driven by this block as in_stall): an add
// transaction carries one item byte; last_byte closes the item. A read
// transaction returns one filter byte. Output channel (out_valid, out_stall
// from the receiver) carries one result per read and per item hash function.
// Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data and
// are taken only while the block is idle or clearing the filter.
// A non-final add byte is stored and the next byte may follow at once. A
// read result is valid once the filter memory has been read (S_RDWAIT), and
// the next input is taken in the cycle after the result leaves. The final
// byte hashes the item once per hash function on one shared multiplier:
// seed load, byte-wise fetch and mixing of each four-byte block and of the
// tail, length and multiply finalization, a bit-serial remainder, a
// read-modify-write of the filter byte and the handover of the result.
// The filter lives in a byte-wide memory; after reset a clearing pass
// zeroes it while no input transaction is taken.
// When the receiver stalls, the result is held and the engine waits.
module bloom_filter_insert_murmur3 #(
    parameter int MAX_ITEM_BYTES     = 128,
    parameter int MAX_FILTER_BYTES   = 255,
    parameter int MAX_HASH_FUNCTIONS = 50
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [7:0]  read_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] bit_index,
    output logic [7:0]  filter_byte,
    output logic        item_too_long,
    output logic        last_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import bfim_pkg::*;

    localparam int LW = $clog2(MAX_ITEM_BYTES + 1);
    localparam int IW = $clog2(MAX_ITEM_BYTES);
    localparam int FW = (MAX_FILTER_BYTES > 1) ? $clog2(MAX_FILTER_BYTES) : 1;
    localparam int HW = $clog2(MAX_HASH_FUNCTIONS + 1);
    localparam int WW = $clog2(MAX_ITEM_BYTES / 4 + 1) + 1;

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_RDWAIT = 15'b000000000000100,
        S_OUT    = 15'b000000000001000,
        S_SEED   = 15'b000000000010000,
        S_FETCH  = 15'b000000000100000,
        S_FWAIT  = 15'b000000001000000,
        S_KMUL1  = 15'b000000010000000,
        S_KMUL2  = 15'b000000100000000,
        S_HBLK   = 15'b000001000000000,
        S_FIN    = 15'b000010000000000,
        S_MOD    = 15'b000100000000000,
        S_SETRD  = 15'b001000000000000,
        S_SETWR  = 15'b010000000000000,
        S_FIN2   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [7:0]  filter_bytes_reg;
    logic [5:0]  hash_count_reg;
    logic [31:0] tweak_reg;
    logic [31:0] seed_step_reg;

    // Item tracking.
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [WW-1:0] word_reg, word_next;
    logic [1:0]    bsel_reg, bsel_next;
    logic [1:0]    fsub_reg, fsub_next;
    logic [HW-1:0] fn_reg, fn_next;
    logic [FW-1:0] clr_reg, clr_next;
    logic [31:0]   kw_reg, kw_next;

    // Result register.
    logic          ov_reg, ov_next;
    logic [10:0]   obit_reg, obit_next;
    logic [7:0]    obyte_reg, obyte_next;
    logic          olast_reg, olast_next;
    logic          rdrange_reg, rdrange_next;
    logic          after_out_reg, after_out_next;

    // Memories.
    logic [7:0] item_mem [MAX_ITEM_BYTES];
    logic [7:0] item_q;
    logic [7:0] filt_mem [MAX_FILTER_BYTES];
    logic [7:0] filt_q;
    logic       im_we;
    logic [IW-1:0] im_addr;
    logic       fm_we;
    logic [FW-1:0] fm_addr;
    logic [7:0] fm_wdata;

    // Hash and remainder units.
    hash_op_t    op;
    logic        seed_init;
    logic        k_load;
    logic [31:0] hash;
    logic        mod_start;
    logic        mod_done;
    logic [11:0] mod_rem;
    logic [11:0] nbits;
    logic [7:0]  eff_bytes;
    logic [HW-1:0] eff_count;
    logic [LW-1:0] nblocks;
    logic [1:0]    rest;
    logic          in_acc;
    logic [LW-1:0] byte_pos;

    assign in_acc = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) || (state_reg == S_CLEAR);

    always_comb
    begin
        if (filter_bytes_reg == 8'd0)
        begin
            eff_bytes = 8'd1;
        end
        else if (32'(filter_bytes_reg) > 32'(MAX_FILTER_BYTES))
        begin
            eff_bytes = 8'(MAX_FILTER_BYTES);
        end
        else
        begin
            eff_bytes = filter_bytes_reg;
        end
        if (32'(hash_count_reg) > 32'(MAX_HASH_FUNCTIONS))
        begin
            eff_count = HW'(MAX_HASH_FUNCTIONS);
        end
        else
        begin
            eff_count = HW'(hash_count_reg);
        end
    end

    assign nbits   = {1'b0, eff_bytes, 3'b000};
    assign nblocks = len_reg >> 2;
    assign rest    = len_reg[1:0];
    assign byte_pos = LW'({word_reg, bsel_reg});

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_bytes_reg <= 8'd1;
            hash_count_reg   <= '0;
            tweak_reg        <= '0;
            seed_step_reg    <= SEED_STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FILTER_BYTES: filter_bytes_reg <= cfg_data[7:0];
                REG_HASH_COUNT:   hash_count_reg   <= cfg_data[5:0];
                REG_TWEAK:        tweak_reg        <= cfg_data;
                REG_SEED_STEP:    seed_step_reg    <= cfg_data;
                default:          tweak_reg        <= tweak_reg;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        word_next      = word_reg;
        bsel_next      = bsel_reg;
        fsub_next      = fsub_reg;
        fn_next        = fn_reg;
        clr_next       = clr_reg;
        kw_next        = kw_reg;
        ov_next        = ov_reg;
        obit_next      = obit_reg;
        obyte_next     = obyte_reg;
        olast_next     = olast_reg;
        rdrange_next   = rdrange_reg;
        after_out_next = after_out_reg;
        op             = OP_NONE;
        seed_init      = 1'b0;
        k_load         = 1'b0;
        mod_start      = 1'b0;
        im_we          = 1'b0;
        im_addr        = IW'(len_reg);
        fm_we          = 1'b0;
        fm_addr        = FW'(read_address);
        fm_wdata       = '0;
        case (state_reg)
            S_CLEAR:
            begin
                fm_we    = 1'b1;
                fm_addr  = clr_reg;
                fm_wdata = '0;
                clr_next = clr_reg + FW'(1);
                if (32'(clr_reg) == MAX_FILTER_BYTES - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (action == ACT_READ)
                    begin
                        fm_addr      = FW'(read_address);
                        rdrange_next = (read_address < eff_bytes);
                        state_next   = S_RDWAIT;
                    end
                    else
                    begin
                        if (32'(len_reg) < MAX_ITEM_BYTES)
                        begin
                            im_we    = 1'b1;
                            len_next = len_reg + LW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (last_byte)
                        begin
                            fn_next   = '0;
                            seed_init = 1'b1;
                            if (eff_count == '0)
                            begin
                                len_next = '0;
                                ovf_next = 1'b0;
                            end
                            else
                            begin
                                state_next = S_SEED;
                            end
                        end
                    end
                end
            end
            S_RDWAIT:
            begin
                ov_next        = 1'b1;
                obit_next      = '0;
                obyte_next     = rdrange_reg ? filt_q : 8'd0;
                olast_next     = 1'b1;
                after_out_next = 1'b0;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    if (after_out_reg)
                    begin
                        state_next = S_SEED;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SEED:
            begin
                op        = OP_LOAD_SEED;
                word_next = '0;
                bsel_next = '0;
                kw_next   = '0;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                // Read the item bytes one at a time into the key word.
                im_addr = IW'(byte_pos);
                if (LW'(word_reg) < nblocks)
                begin
                    state_next = S_FWAIT;
                end
                else if (rest != 2'd0 && bsel_reg < rest)
                begin
                    state_next = S_FWAIT;
                end
                else if (rest != 2'd0)
                begin
                    k_load     = 1'b1;
                    fsub_next  = 2'd1;
                    state_next = S_KMUL1;
                end
                else
                begin
                    state_next = S_FIN;
                    fsub_next  = 2'd0;
                end
            end
            S_FWAIT:
            begin
                kw_next = kw_reg | (32'(item_q) << {bsel_reg, 3'b000});
                bsel_next = bsel_reg + 2'd1;
                if (LW'(word_reg) < nblocks && bsel_reg == 2'd3)
                begin
                    state_next = S_KMUL1;
                    fsub_next  = 2'd0;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_KMUL1:
            begin
                if (fsub_reg == 2'd0 && bsel_reg == 2'd0)
                begin
                    op = OP_K_MUL1;
                end
                else
                begin
                    op = OP_K_MUL1;
                end
                state_next = S_KMUL2;
            end
            S_KMUL2:
            begin
                op         = OP_K_MUL2;
                state_next = S_HBLK;
            end
            S_HBLK:
            begin
                if (fsub_reg == 2'd1)
                begin
                    op         = OP_H_TAIL;
                    fsub_next  = 2'd0;
                    state_next = S_FIN;
                end
                else if (fsub_reg == 2'd2)
                begin
                    op         = OP_H_MUL5;
                    word_next  = word_reg + WW'(1);
                    bsel_next  = '0;
                    kw_next    = '0;
                    fsub_next  = 2'd0;
                    state_next = S_FETCH;
                end
                else
                begin
                    op         = OP_H_BLOCK;
                    fsub_next  = 2'd2;
                end
            end
            S_FIN:
            begin
                op         = OP_FIN_LEN;
                state_next = S_FIN2;
                fsub_next  = 2'd0;
            end
            S_FIN2:
            begin
                if (fsub_reg == 2'd0)
                begin
                    op        = OP_FIN_MUL1;
                    fsub_next = 2'd1;
                end
                else if (fsub_reg == 2'd1)
                begin
                    op        = OP_FIN_MUL2;
                    fsub_next = 2'd2;
                end
                else
                begin
                    mod_start  = 1'b1;
                    op         = OP_SEED_NEXT;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    obit_next  = mod_rem[10:0];
                    state_next = S_SETRD;
                end
            end
            S_SETRD:
            begin
                fm_addr    = FW'(obit_reg[10:3]);
                state_next = S_SETWR;
            end
            S_SETWR:
            begin
                fm_we          = 1'b1;
                fm_addr        = FW'(obit_reg[10:3]);
                fm_wdata       = filt_q | (8'd1 << obit_reg[2:0]);
                ov_next        = 1'b1;
                obyte_next     = '0;
                olast_next     = (fn_reg + HW'(1) == eff_count);
                after_out_next = (fn_reg + HW'(1) != eff_count);
                fn_next        = fn_reg + HW'(1);
                if (fn_reg + HW'(1) == eff_count)
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                end
                state_next = S_OUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The key register of the hash unit takes the assembled word.
    logic [31:0] k_word;
    assign k_word = kw_next;

    bfim_hash_unit u_hash
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .seed_init (seed_init),
        .tweak     (tweak_reg),
        .seed_step (seed_step_reg),
        .k_load    (k_load || (state_reg == S_FWAIT && state_next == S_KMUL1)),
        .k_in      (k_load ? kw_reg : k_word),
        .len       (32'(len_reg)),
        .hash      (hash)
    );

    bfim_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (hash),
        .divisor   (nbits),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Item buffer memory.
    always_ff @(posedge clk)
    begin
        if (im_we)
        begin
            item_mem[im_addr] <= data_byte;
        end
        item_q <= item_mem[im_addr];
    end

    // Filter memory, one byte per row.
    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            filt_mem[fm_addr] <= fm_wdata;
        end
        filt_q <= filt_mem[fm_addr];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            fn_reg        <= '0;
            clr_reg       <= '0;
            ov_reg        <= 1'b0;
            after_out_reg <= 1'b0;
            fsub_reg      <= '0;
            word_reg      <= '0;
            bsel_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            fn_reg        <= fn_next;
            clr_reg       <= clr_next;
            ov_reg        <= ov_next;
            after_out_reg <= after_out_next;
            fsub_reg      <= fsub_next;
            word_reg      <= word_next;
            bsel_reg      <= bsel_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kw_reg      <= kw_next;
        obit_reg    <= obit_next;
        obyte_reg   <= obyte_next;
        olast_reg   <= olast_next;
        rdrange_reg <= rdrange_next;
    end

    // The overflow flag is captured for all results of an item.
    logic oflag_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RDWAIT)
        begin
            oflag_reg <= 1'b0;
        end
        else if (state_reg == S_SETWR)
        begin
            oflag_reg <= ovf_reg;
        end
    end

    assign out_valid     = ov_reg;
    assign bit_index     = obit_reg;
    assign filter_byte   = obyte_reg;
    assign item_too_long = oflag_reg;
    assign last_result   = olast_reg;

endmodule

[rtl/core/bfim_hash_unit.sv]
module bfim_hash_unit
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bfim_pkg::hash_op_t     op,
    input  logic                   seed_init,
    input  logic [31:0]            tweak,
    input  logic [31:0]            seed_step,
    input  logic                   k_load,
    input  logic [31:0]            k_in,
    input  logic [31:0]            len,
    output logic [31:0]            hash
);
    import bfim_pkg::*;

    logic [31:0] h_reg;
    logic [31:0] h_next;
    logic [31:0] k_reg;
    logic [31:0] k_next;
    logic [31:0] seed_reg;
    logic [31:0] seed_next;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_p;
    logic [31:0] t;

    // Operand selection for the single shared 32x32 multiplier.
    always_comb
    begin
        mul_a = k_reg;
        mul_b = MM3_C1;
        case (op)
            OP_K_MUL1:
            begin
                mul_a = k_reg;
                mul_b = MM3_C1;
            end
            OP_K_MUL2:
            begin
                mul_a = {k_reg[16:0], k_reg[31:17]};
                mul_b = MM3_C2;
            end
            OP_H_MUL5:
            begin
                mul_a = h_reg;
                mul_b = 32'd5;
            end
            OP_FIN_MUL1:
            begin
                mul_a = h_reg;
                mul_b = MM3_F1;
            end
            OP_FIN_MUL2:
            begin
                mul_a = h_reg;
                mul_b = MM3_F2;
            end
            default:
            begin
                mul_a = k_reg;
                mul_b = MM3_C1;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Next-state logic of the hash, key and seed registers.
    always_comb
    begin
        h_next    = h_reg;
        k_next    = k_load ? k_in : k_reg;
        seed_next = seed_init ? tweak : seed_reg;
        t         = h_reg ^ k_reg;
        case (op)
            OP_LOAD_SEED: h_next = seed_reg;
            OP_K_MUL1:    k_next = mul_p;
            OP_K_MUL2:    k_next = mul_p;
            OP_H_BLOCK:   h_next = {t[18:0], t[31:19]};
            OP_H_MUL5:    h_next = mul_p + MM3_N;
            OP_H_TAIL:    h_next = t;
            OP_FIN_LEN:
            begin
                t      = h_reg ^ len;
                h_next = t ^ (t >> 16);
            end
            OP_FIN_MUL1:  h_next = mul_p ^ (mul_p >> 13);
            OP_FIN_MUL2:  h_next = mul_p ^ (mul_p >> 16);
            OP_SEED_NEXT: seed_next = seed_reg + seed_step;
            default:      h_next = h_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        k_reg <= k_next;
    end

    assign hash = h_reg;

endmodule

[rtl/core/bfim_mod_unit.sv]
module bfim_mod_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [11:0] divisor,
    output logic        done,
    output logic [11:0] remainder
);
    // Restoring remainder, one dividend bit per cycle.
    logic [31:0] q_reg;
    logic [31:0] q_next;
    logic [12:0] r_reg;
    logic [12:0] r_next;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic [12:0] shifted;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {r_reg[11:0], q_reg[31]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[30:0], 1'b0};
            r_next   = (shifted >= {1'b0, divisor}) ? shifted - {1'b0, divisor} : shifted;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done      = busy_reg && (cnt_reg == 6'd1);
    assign remainder = r_next[11:0];

endmodule

[rtl/core/bfim_checker.sv]
module bfim_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [10:0] bit_index,
    input logic [7:0]  filter_byte,
    input logic        last_result
);
    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bit_index) && $stable(filter_byte))
        else $error("stalled result changed");

    // A stalled input transaction stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("stalled input withdrawn");

    // No input is taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while result pending");

    // Insert results carry no filter byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bit_index != 11'd0 |-> filter_byte == 8'd0)
        else $error("insert result with filter byte");

    // A read result ends its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && filter_byte != 8'd0 |-> last_result)
        else $error("read result not last");
endmodule

bind bloom_filter_insert_murmur3 bfim_checker u_bfim_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bit_index   (bit_index),
    .filter_byte (filter_byte),
    .last_result (last_result)
);
